// File: rtl/core/process_fifo_with_remove_unit_macros.svh
// Assertion macros for the process queue unit.
// Used by the port checker; no other dependencies.
`ifndef PROCESS_FIFO_WITH_REMOVE_UNIT_MACROS_SVH
`define PROCESS_FIFO_WITH_REMOVE_UNIT_MACROS_SVH

// Checked only while out of reset.
`define PFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pfr_pkg.sv
// Shared types, constants and helpers for the process queue unit.
// No dependencies; imported by every module of the unit.
package pfr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int PID_W      = 16;
   localparam int PRI_W      = 8;
   localparam int OCC_W      = 5;
   localparam int REQ_W      = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_FLD_W  = 1 + PID_W + PRI_W + OCC_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FLD_W;

   // Bit positions in the response word
   localparam int RSP_OK_BIT  = 0;
   localparam int RSP_PID_LO  = 1;
   localparam int RSP_PRI_HI  = PID_W + PRI_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [PRI_W-1:0] prio;
      logic [PID_W-1:0] pid;
   } entry_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_REMOVE  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } mem_req_type;

   function automatic idx_type idx_next(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type idx_prev(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : idx_type'(i - 1'b1);
   endfunction

endpackage

// File: rtl/core/pfr_entry_ram.sv
// Entry store of the process queue: one write port, one registered read port.
// Depends on pfr_pkg for the entry and request types.
module pfr_entry_ram
   import pfr_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/process_fifo_with_remove_unit.sv
// Ordered process queue with remove by id. Entries live in a ring buffer in a
// single-port-read synchronous RAM of DEPTH words. Enqueue, and any request that
// is refused, is answered from the idle state; the next word can follow right
// behind it once that response leaves. Dequeue passes through a RAM read, a
// pointer update and a response step. Remove scans from the head one entry per
// cycle through the RAM read port, then closes the gap by moving every later
// entry down one slot, one per cycle. No clearing pass runs after reset: slots
// are read only once written. A finished response waits in an output register;
// a new request word is taken only when that register is empty or its word
// leaves in the same cycle.
// Depends on pfr_pkg and pfr_entry_ram.
module process_fifo_with_remove_unit
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tuser,   // req_type
   input  logic [REQ_DATA_W-1:0] req_tdata,   // in_pid[15:0], in_priority[23:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // ok, out_pid, out_priority, occupancy, pad
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   idx_type   head_ff, head_in;
   idx_type   tail_ff, tail_in;
   cnt_type   count_ff, count_in;
   cnt_type   remain_ff, remain_in;
   idx_type   scan_ptr_ff, scan_ptr_in;
   idx_type   rd_ptr_ff, rd_ptr_in;
   logic [PID_W-1:0] key_ff, key_in;
   entry_type res_ff, res_in;
   logic      res_ok_ff, res_ok_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   mem_req_type mem_req;
   entry_type   rd_data;
   entry_type   req_entry;
   logic        out_free;
   logic        req_fire;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(logic ok, entry_type e, cnt_type c);
      return {{RSP_PAD_W{1'b0}}, OCC_W'(c), e.prio, e.pid, ok};
   endfunction

   pfr_entry_ram u_pfr_entry_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_entry  = entry_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      scan_ptr_in  = scan_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < cnt_type'(DEPTH)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = tail_ff;
                        mem_req.wr_data = req_entry;
                        tail_in         = idx_next(tail_ff);
                        count_in        = count_ff + 1'b1;
                        rsp_data_in     = pack_rsp(1'b1, '0, count_ff + 1'b1);
                     end else begin
                        rsp_data_in = pack_rsp(1'b0, '0, count_ff);
                     end
                  end
                  REQ_DEQUEUE: begin
                     if (count_ff != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_ff;
                        state_in        = ST_DEQ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = pack_rsp(1'b0, '0, count_ff);
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_ff;
                        scan_ptr_in     = head_ff;
                        remain_in       = count_ff - 1'b1;
                        key_in          = req_entry.pid;
                        state_in        = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = pack_rsp(1'b0, '0, count_ff);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(1'b0, '0, count_ff);
                  end
               endcase
            end
         end
         ST_DEQ: begin
            res_in    = rd_data;
            res_ok_in = 1'b1;
            head_in   = idx_next(head_ff);
            count_in  = count_ff - 1'b1;
            state_in  = ST_RESP;
         end
         ST_SCAN: begin
            if (rd_data.pid == key_ff) begin
               res_in    = rd_data;
               res_ok_in = 1'b1;
               if (remain_ff == '0) begin
                  // hit on the tail entry: nothing to move
                  tail_in  = idx_prev(tail_ff);
                  count_in = count_ff - 1'b1;
                  state_in = ST_RESP;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_next(scan_ptr_ff);
                  rd_ptr_in       = idx_next(scan_ptr_ff);
                  state_in        = ST_SHIFT;
               end
            end else if (remain_ff == '0) begin
               res_in    = '0;
               res_ok_in = 1'b0;
               state_in  = ST_RESP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_next(scan_ptr_ff);
               scan_ptr_in     = idx_next(scan_ptr_ff);
               remain_in       = remain_ff - 1'b1;
            end
         end
         ST_SHIFT: begin
            // move the entry just read into the hole; the hole advances to it
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_ptr_ff;
            mem_req.wr_data = rd_data;
            scan_ptr_in     = rd_ptr_ff;
            if (remain_ff == cnt_type'(1)) begin
               tail_in  = idx_prev(tail_ff);
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_next(rd_ptr_ff);
               rd_ptr_in       = idx_next(rd_ptr_ff);
               remain_in       = remain_ff - 1'b1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_rsp(res_ok_ff, res_ok_ff ? res_ff : '0, count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff   <= remain_in;
      scan_ptr_ff <= scan_ptr_in;
      rd_ptr_ff   <= rd_ptr_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/pfr_checker.sv
// Port-level checks on the process queue unit, bound to the top level.
// Depends on pfr_pkg and process_fifo_with_remove_unit_macros.svh.
`include "process_fifo_with_remove_unit_macros.svh"

module pfr_checker
   import pfr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic fail_word;
   logic entry_zero;

   assign fail_word  = rsp_tvalid && !rsp_tdata[RSP_OK_BIT];
   assign entry_zero = (rsp_tdata[RSP_PRI_HI:RSP_PID_LO] == '0);

   `PFR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")
   `PFR_ASSERT(a_fail_zero, clock, reset, fail_word |-> entry_zero, "refused request returned a nonzero entry")
   `PFR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response valid right after reset")
   `PFR_ASSERT(a_no_take_when_full_stall, clock, reset, req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready, "request taken while response register blocked")

endmodule

bind process_fifo_with_remove_unit pfr_checker u_pfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
